// File: hw/rtl/ppu_pkg.sv
// Shared types and constants for the particle pool.
`default_nettype none
package ppu_pkg;
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_SPAWN = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;
   localparam logic [1:0] OP_READ  = 2'd3;
   localparam logic [31:0] GOLDEN_MULT = 32'd2654435761;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [23:0] delta_time;
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [31:0] vel_x;
      logic [31:0] vel_y;
      logic [31:0] lifetime;
      logic [5:0]  read_index;
   } cmd_type;

   typedef struct packed {
      logic        spawn_ok;
      logic [5:0]  slot_index;
      logic [31:0] seed;
      logic [6:0]  alive_count;
      logic        slot_alive;
      logic [31:0] slot_pos_x;
      logic [31:0] slot_pos_y;
      logic [31:0] slot_age;
   } rsp_type;
endpackage
`default_nettype wire

// File: hw/rtl/particle_pool_update.sv
// Particle pool: a 2-deep command queue, then a slot engine over the slot memories.
// Tick and clear walk every slot in turn (read, multiply, write back per slot through one memory
// port); spawn writes the free slot and reads it back; read fetches one slot.
// The engine takes one item at a time, none new until it is done; the queue holds two more,
// and a response not yet taken holds the engine before it issues the next.
// Reset (sync, active high) zeroes counter and queue, then clears all slots with a silent clear walk.
`default_nettype none
module particle_pool_update #(
   parameter int CAPACITY = 64
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_valid,
   output logic         req_ready,
   input  wire  [1:0]   req_opcode,
   input  wire  [23:0]  req_delta_time,
   input  wire  [31:0]  req_spawn_pos_x,
   input  wire  [31:0]  req_spawn_pos_y,
   input  wire  [31:0]  req_spawn_vel_x,
   input  wire  [31:0]  req_spawn_vel_y,
   input  wire  [31:0]  req_spawn_lifetime,
   input  wire  [5:0]   req_read_index,
   output logic         rsp_valid,
   input  wire          rsp_ready,
   output logic         rsp_spawn_ok,
   output logic [5:0]   rsp_slot_index,
   output logic [31:0]  rsp_seed,
   output logic [6:0]   rsp_alive_count,
   output logic         rsp_slot_alive,
   output logic [31:0]  rsp_slot_pos_x,
   output logic [31:0]  rsp_slot_pos_y,
   output logic [31:0]  rsp_slot_age
);
   import ppu_pkg::*;
   cmd_type in_cmd, q_cmd;
   rsp_type r;
   logic    q_valid, q_ready;

   assign in_cmd = '{opcode: req_opcode, delta_time: req_delta_time,
                     pos_x: req_spawn_pos_x, pos_y: req_spawn_pos_y,
                     vel_x: req_spawn_vel_x, vel_y: req_spawn_vel_y,
                     lifetime: req_spawn_lifetime, read_index: req_read_index};

   ppu_cmd_fifo u_fifo (
      .clock, .reset, .in_valid(req_valid), .in_ready(req_ready), .in_cmd(in_cmd),
      .out_valid(q_valid), .out_ready(q_ready), .out_cmd(q_cmd)
   );

   ppu_engine #(.CAPACITY(CAPACITY)) u_engine (
      .clock, .reset, .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
      .rsp_valid, .rsp_ready, .rsp(r)
   );

   assign rsp_spawn_ok    = r.spawn_ok;
   assign rsp_slot_index  = r.slot_index;
   assign rsp_seed        = r.seed;
   assign rsp_alive_count = r.alive_count;
   assign rsp_slot_alive  = r.slot_alive;
   assign rsp_slot_pos_x  = r.slot_pos_x;
   assign rsp_slot_pos_y  = r.slot_pos_y;
   assign rsp_slot_age    = r.slot_age;
endmodule
`default_nettype wire

// File: hw/rtl/ppu_cmd_fifo.sv
// Two-entry command queue between the front end and the slot engine.
`default_nettype none
module ppu_cmd_fifo (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  in_valid,
   output logic                 in_ready,
   input  ppu_pkg::cmd_type     in_cmd,
   output logic                 out_valid,
   input  wire                  out_ready,
   output ppu_pkg::cmd_type     out_cmd
);
   import ppu_pkg::*;
   cmd_type    mem_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] cnt_ff;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_cmd   = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) mem_ff[wr_ff] <= in_cmd;
      if (reset) begin
         wr_ff <= 1'b0; rd_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         if (in_valid && in_ready) wr_ff <= ~wr_ff;
         if (out_valid && out_ready) rd_ff <= ~rd_ff;
         cnt_ff <= cnt_ff + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
      end
   end
endmodule
`default_nettype wire

// File: hw/rtl/ppu_engine.sv
// Slot engine: walks the slot memories for tick, clear, spawn and read.
`default_nettype none
module ppu_engine #(
   parameter int CAPACITY = 64
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  cmd_valid,
   output logic                 cmd_ready,
   input  ppu_pkg::cmd_type     cmd,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output ppu_pkg::rsp_type     rsp
);
   import ppu_pkg::*;
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_WALK, S_CALC, S_WRITE, S_SPAWN_RD, S_READ, S_DONE
   } state_type;

   // Slot memories; one write port, one registered read port.
   logic [31:0] px_mem [CAPACITY];
   logic [31:0] py_mem [CAPACITY];
   logic [31:0] vx_mem [CAPACITY];
   logic [31:0] vy_mem [CAPACITY];
   logic [31:0] age_mem [CAPACITY];
   logic [31:0] life_mem [CAPACITY];
   logic [31:0] seed_mem [CAPACITY];
   logic [CAPACITY-1:0] alive_ff;

   state_type   state_ff;
   cmd_type     cmd_ff;
   logic [AW-1:0] idx_ff;
   logic [CW-1:0] count_ff;
   logic [31:0] counter_ff;
   logic [31:0] px_rd_ff, py_rd_ff, vx_rd_ff, vy_rd_ff, age_rd_ff, life_rd_ff, seed_rd_ff;
   logic [55:0] stepx_ff, stepy_ff;
   rsp_type     rsp_ff;
   rsp_type     rsp_next;
   logic        rsp_valid_ff;
   logic        init_ff;
   logic        we;
   logic [AW-1:0] wa;
   logic [31:0] w_px, w_py, w_vx, w_vy, w_age, w_life, w_seed;

   // Lowest free slot.
   logic [AW-1:0] free_idx;
   logic          free_found;
   always_comb begin
      free_idx = '0; free_found = 1'b0;
      for (int i = CAPACITY - 1; i >= 0; i--)
         if (!alive_ff[i]) begin free_idx = AW'(i); free_found = 1'b1; end
   end

   function automatic logic [31:0] sat_add(input logic [31:0] p, input logic [55:0] prod);
      logic signed [40:0] s;
      s = 41'($signed(p)) + 41'($signed(prod[55:16]));
      if (s > 41'sh7FFFFFFF) return 32'h7FFFFFFF;
      else if (s < -41'sh80000000) return 32'h80000000;
      else return s[31:0];
   endfunction

   logic [32:0] age_sum;
   logic [31:0] age_new;
   assign age_sum = {1'b0, age_rd_ff} + 33'(cmd_ff.delta_time);
   assign age_new = age_sum[32] ? 32'hFFFFFFFF : age_sum[31:0];
   logic [31:0] next_ctr;
   assign next_ctr = counter_ff + 32'd1;

   // Spawn success is remembered from the front search.
   logic spawn_hit_ff;
   always_ff @(posedge clock) begin
      if (reset) spawn_hit_ff <= 1'b0;
      else if (state_ff == S_IDLE && cmd_valid) spawn_hit_ff <= free_found;
   end

   assign cmd_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_comb begin
      we = 1'b0; wa = idx_ff;
      w_px = '0; w_py = '0; w_vx = '0; w_vy = '0; w_age = '0; w_life = '0; w_seed = '0;
      unique case (state_ff)
         S_WRITE: begin
            if (cmd_ff.opcode == OP_CLEAR) we = 1'b1;
            else if (alive_ff[idx_ff]) begin
               we = 1'b1;
               w_px = sat_add(px_rd_ff, stepx_ff);
               w_py = sat_add(py_rd_ff, stepy_ff);
               w_vx = vx_rd_ff; w_vy = vy_rd_ff; w_age = age_new;
               w_life = life_rd_ff; w_seed = seed_rd_ff;
            end
         end
         S_SPAWN_RD: begin
            we = 1'b1;
            w_px = cmd_ff.pos_x; w_py = cmd_ff.pos_y;
            w_vx = cmd_ff.vel_x; w_vy = cmd_ff.vel_y;
            w_life = cmd_ff.lifetime; w_seed = next_ctr * GOLDEN_MULT;
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_next = '0;
      rsp_next.alive_count = (32'(count_ff) > 127) ? 7'd127 : 7'(count_ff);
      if (cmd_ff.opcode == OP_SPAWN && spawn_hit_ff) begin
         rsp_next.spawn_ok = 1'b1;
         rsp_next.slot_index = 6'(idx_ff);
         rsp_next.seed = seed_rd_ff;
         rsp_next.slot_alive = 1'b1;
         rsp_next.slot_pos_x = px_rd_ff;
         rsp_next.slot_pos_y = py_rd_ff;
         rsp_next.slot_age = age_rd_ff;
      end else if (cmd_ff.opcode == OP_READ) begin
         rsp_next.slot_index = cmd_ff.read_index;
         if (32'(cmd_ff.read_index) < CAPACITY) begin
            rsp_next.seed = seed_rd_ff;
            rsp_next.slot_alive = alive_ff[idx_ff];
            rsp_next.slot_pos_x = px_rd_ff;
            rsp_next.slot_pos_y = py_rd_ff;
            rsp_next.slot_age = age_rd_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         px_mem[wa] <= w_px; py_mem[wa] <= w_py; vx_mem[wa] <= w_vx; vy_mem[wa] <= w_vy;
         age_mem[wa] <= w_age; life_mem[wa] <= w_life; seed_mem[wa] <= w_seed;
      end
      px_rd_ff <= px_mem[idx_ff]; py_rd_ff <= py_mem[idx_ff];
      vx_rd_ff <= vx_mem[idx_ff]; vy_rd_ff <= vy_mem[idx_ff];
      age_rd_ff <= age_mem[idx_ff]; life_rd_ff <= life_mem[idx_ff];
      seed_rd_ff <= seed_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         // Start with a silent clear walk so every slot reads as zero.
         state_ff <= S_WALK; alive_ff <= '0; count_ff <= '0; counter_ff <= '0;
         rsp_valid_ff <= 1'b0; idx_ff <= '0; init_ff <= 1'b1;
         cmd_ff.opcode <= OP_CLEAR;
      end else begin
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (cmd_valid) begin
               cmd_ff <= cmd;
               unique case (cmd.opcode)
                  OP_TICK, OP_CLEAR: begin
                     idx_ff <= '0;
                     state_ff <= S_WALK;
                  end
                  OP_SPAWN: begin
                     idx_ff <= free_idx;
                     state_ff <= free_found ? S_SPAWN_RD : S_DONE;
                  end
                  OP_READ: begin
                     idx_ff <= AW'(cmd.read_index);
                     state_ff <= S_READ;
                  end
               endcase
            end
            S_WALK: state_ff <= S_CALC; // memory read in flight
            S_CALC: begin
               stepx_ff <= 56'($signed(vx_rd_ff) * $signed({1'b0, cmd_ff.delta_time}));
               stepy_ff <= 56'($signed(vy_rd_ff) * $signed({1'b0, cmd_ff.delta_time}));
               state_ff <= S_WRITE;
            end
            S_WRITE: begin
               if (cmd_ff.opcode == OP_CLEAR) begin
                  alive_ff[idx_ff] <= 1'b0;
               end else if (alive_ff[idx_ff] && life_rd_ff != 0 && age_new >= life_rd_ff) begin
                  alive_ff[idx_ff] <= 1'b0;
                  count_ff <= count_ff - CW'(1);
               end
               if (32'(idx_ff) == CAPACITY - 1) begin
                  if (cmd_ff.opcode == OP_CLEAR) count_ff <= '0;
                  state_ff <= S_DONE;
               end else begin
                  idx_ff <= idx_ff + AW'(1);
                  state_ff <= S_WALK;
               end
            end
            S_SPAWN_RD: begin
               alive_ff[idx_ff] <= 1'b1;
               count_ff <= count_ff + CW'(1);
               counter_ff <= next_ctr;
               // read the new slot back before reporting it
               state_ff <= S_READ;
            end
            S_READ: state_ff <= S_DONE;
            S_DONE: if (init_ff) begin
               init_ff <= 1'b0;
               state_ff <= S_IDLE;
            end else if (!rsp_valid_ff) begin
               rsp_valid_ff <= 1'b1;
               rsp_ff <= rsp_next;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// File: dv/particle_pool_update_tb.sv
// Self-checking testbench for the particle pool: predicts every response and compares it.
`timescale 1ns / 1ps
module particle_pool_update_tb;
   import ppu_pkg::*;

   localparam int SLOTS = 64;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_accepted = 1'b0;
   logic [1:0] req_opcode = OP_TICK;
   logic [23:0] req_delta_time = '0;
   logic [31:0] req_spawn_pos_x = '0;
   logic [31:0] req_spawn_pos_y = '0;
   logic [31:0] req_spawn_vel_x = '0;
   logic [31:0] req_spawn_vel_y = '0;
   logic [31:0] req_spawn_lifetime = '0;
   logic [5:0] req_read_index = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_spawn_ok;
   logic [5:0] rsp_slot_index;
   logic [31:0] rsp_seed;
   logic [6:0] rsp_alive_count;
   logic rsp_slot_alive;
   logic [31:0] rsp_slot_pos_x;
   logic [31:0] rsp_slot_pos_y;
   logic [31:0] rsp_slot_age;

   particle_pool_update #(.CAPACITY(SLOTS)) DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_opcode(req_opcode), .req_delta_time(req_delta_time),
      .req_spawn_pos_x(req_spawn_pos_x), .req_spawn_pos_y(req_spawn_pos_y),
      .req_spawn_vel_x(req_spawn_vel_x), .req_spawn_vel_y(req_spawn_vel_y),
      .req_spawn_lifetime(req_spawn_lifetime), .req_read_index(req_read_index),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_spawn_ok(rsp_spawn_ok), .rsp_slot_index(rsp_slot_index),
      .rsp_seed(rsp_seed), .rsp_alive_count(rsp_alive_count),
      .rsp_slot_alive(rsp_slot_alive), .rsp_slot_pos_x(rsp_slot_pos_x),
      .rsp_slot_pos_y(rsp_slot_pos_y), .rsp_slot_age(rsp_slot_age)
   );

   // Pool shadow
   logic        live_q [SLOTS];
   logic [31:0] px_q [SLOTS], py_q [SLOTS], vx_q [SLOTS], vy_q [SLOTS];
   logic [31:0] age_q [SLOTS], life_q [SLOTS], seed_q [SLOTS];
   logic [31:0] spawn_total;

   cmd_type pending_cmds [$];
   rsp_type expected_rsps [$];
   int      send_idle_pct, recv_idle_pct;
   int      errors, accepted_cmds, checked_rsps;
   int      op_seen [4];

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic logic [31:0] move_axis(logic [31:0] pos, logic [31:0] vel,
                                              logic [23:0] dt);
      logic signed [63:0] prod, sum;
      prod = $signed({{32{vel[31]}}, vel}) * $signed({40'd0, dt});
      prod = prod >>> 16;  // arithmetic shift gives floor
      sum = $signed({{32{pos[31]}}, pos}) + prod;
      if (sum > 64'sd2147483647) sum = 64'sd2147483647;
      if (sum < -64'sd2147483648) sum = -64'sd2147483648;
      return sum[31:0];
   endfunction

   function automatic logic [6:0] live_total();
      int n;
      n = 0;
      for (int i = 0; i < SLOTS; i++) n += live_q[i];
      return n[6:0];
   endfunction

   function automatic void wipe_pool();
      for (int i = 0; i < SLOTS; i++) begin
         live_q[i] = 1'b0; px_q[i] = '0; py_q[i] = '0; vx_q[i] = '0;
         vy_q[i] = '0; age_q[i] = '0; life_q[i] = '0; seed_q[i] = '0;
      end
   endfunction

   function automatic void show_slot(ref rsp_type r, input int i);
      r.slot_index = i[5:0];
      r.seed = seed_q[i];
      r.slot_alive = live_q[i];
      r.slot_pos_x = px_q[i];
      r.slot_pos_y = py_q[i];
      r.slot_age = age_q[i];
   endfunction

   function automatic rsp_type apply_command(cmd_type c);
      rsp_type r;
      logic [32:0] a;
      r = '0;
      case (c.opcode)
         OP_TICK: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (live_q[i]) begin
                  px_q[i] = move_axis(px_q[i], vx_q[i], c.delta_time);
                  py_q[i] = move_axis(py_q[i], vy_q[i], c.delta_time);
                  a = {1'b0, age_q[i]} + c.delta_time;
                  age_q[i] = a[32] ? 32'hFFFF_FFFF : a[31:0];
                  if (life_q[i] != 0 && age_q[i] >= life_q[i]) live_q[i] = 1'b0;
               end
            end
         end
         OP_SPAWN: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (!live_q[i]) begin
                  live_q[i] = 1'b1;
                  px_q[i] = c.pos_x; py_q[i] = c.pos_y;
                  vx_q[i] = c.vel_x; vy_q[i] = c.vel_y;
                  life_q[i] = c.lifetime; age_q[i] = '0;
                  spawn_total = spawn_total + 1;
                  seed_q[i] = spawn_total * GOLDEN_MULT;
                  r.spawn_ok = 1'b1;
                  show_slot(r, i);
                  break;
               end
            end
         end
         OP_CLEAR: wipe_pool();
         default: show_slot(r, c.read_index);
      endcase
      r.alive_count = live_total();
      return r;
   endfunction

   function automatic cmd_type rand_cmd(logic [1:0] op);
      cmd_type c;
      c.opcode = op;
      case ($urandom_range(0, 3))
         0: c.delta_time = 24'($urandom_range(0, 255));
         1: c.delta_time = 24'hFF_FFFF - 24'($urandom_range(0, 3));
         default: c.delta_time = 24'($urandom);
      endcase
      c.pos_x = ($urandom_range(0, 3) == 0) ? $urandom : $signed($urandom_range(0, 1 << 22)) - (1 << 21);
      c.pos_y = ($urandom_range(0, 3) == 0) ? $urandom : $signed($urandom_range(0, 1 << 22)) - (1 << 21);
      c.vel_x = ($urandom_range(0, 3) == 0) ? $urandom : $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      c.vel_y = ($urandom_range(0, 3) == 0) ? $urandom : $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      case ($urandom_range(0, 3))
         0: c.lifetime = '0;
         1: c.lifetime = $urandom;
         default: c.lifetime = $urandom_range(1, 32'h0010_0000);
      endcase
      c.read_index = 6'($urandom);
      return c;
   endfunction

   function automatic void push_cmd(cmd_type c);
      pending_cmds.push_back(c);
   endfunction

   // Driver: present items at the falling edge, hold until accepted.
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !req_accepted) begin
            // hold
         end else if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            cmd_type c;
            c = pending_cmds.pop_front();
            req_valid <= 1'b1;
            req_opcode <= c.opcode;
            req_delta_time <= c.delta_time;
            req_spawn_pos_x <= c.pos_x;
            req_spawn_pos_y <= c.pos_y;
            req_spawn_vel_x <= c.vel_x;
            req_spawn_vel_y <= c.vel_y;
            req_spawn_lifetime <= c.lifetime;
            req_read_index <= c.read_index;
         end else begin
            req_valid <= 1'b0;
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Monitor: predict on acceptance, compare responses.
   always @(posedge clock) begin
      if (!reset) begin
         req_accepted <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            cmd_type c;
            c = '{req_opcode, req_delta_time, req_spawn_pos_x, req_spawn_pos_y,
                  req_spawn_vel_x, req_spawn_vel_y, req_spawn_lifetime, req_read_index};
            expected_rsps.push_back(apply_command(c));
            op_seen[c.opcode]++;
            accepted_cmds++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               $error("unexpected response item");
               errors++;
            end else begin
               rsp_type e;
               e = expected_rsps.pop_front();
               checked_rsps++;
               if (rsp_spawn_ok !== e.spawn_ok) begin
                  $error("spawn_ok exp %0d got %0d", e.spawn_ok, rsp_spawn_ok); errors++;
               end
               if (rsp_slot_index !== e.slot_index) begin
                  $error("slot_index exp %0d got %0d", e.slot_index, rsp_slot_index); errors++;
               end
               if (rsp_seed !== e.seed) begin
                  $error("seed exp %h got %h", e.seed, rsp_seed); errors++;
               end
               if (rsp_alive_count !== e.alive_count) begin
                  $error("alive_count exp %0d got %0d", e.alive_count, rsp_alive_count);
                  errors++;
               end
               if (rsp_slot_alive !== e.slot_alive) begin
                  $error("slot_alive exp %0d got %0d", e.slot_alive, rsp_slot_alive); errors++;
               end
               if (rsp_slot_pos_x !== e.slot_pos_x) begin
                  $error("slot_pos_x exp %h got %h", e.slot_pos_x, rsp_slot_pos_x); errors++;
               end
               if (rsp_slot_pos_y !== e.slot_pos_y) begin
                  $error("slot_pos_y exp %h got %h", e.slot_pos_y, rsp_slot_pos_y); errors++;
               end
               if (rsp_slot_age !== e.slot_age) begin
                  $error("slot_age exp %h got %h", e.slot_age, rsp_slot_age); errors++;
               end
            end
         end
      end
   end

   task automatic drain();
      while (pending_cmds.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      cmd_type c;
      int r;
      wipe_pool();
      spawn_total = '0;
      errors = 0; accepted_cmds = 0; checked_rsps = 0;
      op_seen = '{default: 0};
      send_idle_pct = 9;
      recv_idle_pct = 56;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: extremes, saturation, kill, read beyond use, clear
      c = '0; c.opcode = OP_READ; c.read_index = 6'd63; push_cmd(c);
      c = '0; c.opcode = OP_SPAWN; c.pos_x = 32'h7FFF_FFF0; c.pos_y = 32'h8000_0010;
      c.vel_x = 32'h7FFF_FFFF; c.vel_y = 32'h8000_0000; c.lifetime = '0; push_cmd(c);
      c = '0; c.opcode = OP_SPAWN; c.pos_x = 32'hFFFF_FFFF; c.vel_x = 32'hFFFF_FFFF;
      c.vel_y = 32'h0000_0001; c.lifetime = 32'h0002_0000; push_cmd(c);
      c = '0; c.opcode = OP_SPAWN; c.lifetime = 32'hFFFF_FFFF; c.vel_x = 32'h0001_0000;
      push_cmd(c);
      c = '0; c.opcode = OP_TICK; c.delta_time = 24'd0; push_cmd(c);
      c = '0; c.opcode = OP_TICK; c.delta_time = 24'h00_0001; push_cmd(c);
      c = '0; c.opcode = OP_TICK; c.delta_time = 24'h02_0000; push_cmd(c);
      for (int i = 0; i < 3; i++) begin
         c = '0; c.opcode = OP_READ; c.read_index = 6'(i); push_cmd(c);
      end
      for (int i = 0; i < 300; i++) begin
         c = '0; c.opcode = OP_TICK; c.delta_time = 24'hFF_FFFF; push_cmd(c);
      end
      c = '0; c.opcode = OP_READ; c.read_index = 6'd0; push_cmd(c);
      c = '0; c.opcode = OP_READ; c.read_index = 6'd2; push_cmd(c);
      c = '0; c.opcode = OP_CLEAR; push_cmd(c);
      c = '0; c.opcode = OP_READ; c.read_index = 6'd0; push_cmd(c);
      // Fill the pool and overflow it
      for (int i = 0; i < SLOTS + 2; i++) push_cmd(rand_cmd(OP_SPAWN));
      c = '0; c.opcode = OP_READ; c.read_index = 6'd63; push_cmd(c);
      c = '0; c.opcode = OP_CLEAR; push_cmd(c);
      drain();

      // Random: mostly spawn/tick/read traffic, occasional clear
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 56 : 0;
         recv_idle_pct = (phase == 0) ? 56 : (phase == 1) ? 9 : 0;
         for (int i = 0; i < 70; i++) begin
            r = $urandom_range(0, 99);
            if (r < 40) push_cmd(rand_cmd(OP_SPAWN));
            else if (r < 65) push_cmd(rand_cmd(OP_TICK));
            else if (r < 97) push_cmd(rand_cmd(OP_READ));
            else push_cmd(rand_cmd(OP_CLEAR));
         end
         drain();
      end
      repeat (400) @(posedge clock);

      $display("Accepted %0d items (tick %0d, spawn %0d, clear %0d, read %0d).",
               accepted_cmds, op_seen[0], op_seen[1], op_seen[2], op_seen[3]);
      $display("Checked %0d responses; %0d spawns issued seeds.", checked_rsps, spawn_total);
      if (errors == 0 && expected_rsps.size() == 0) begin
         $display("particle_pool_update test passed");
      end else begin
         $display("particle_pool_update test failed");
      end
      $finish;
   end

   // Slowest run: ~600 items, with stalls; allow far more.
   initial begin
      #(12ns * 2_000_000);
      $display("particle_pool_update test failed");
      $finish;
   end
endmodule

// File: sim.f
hw/rtl/ppu_pkg.sv
hw/rtl/ppu_cmd_fifo.sv
hw/rtl/ppu_engine.sv
hw/rtl/particle_pool_update.sv
dv/particle_pool_update_tb.sv
